// ===== rtl/def_pkg.sv =====
// def_pkg: shared types and constants for the diagonal emboss filter.
// Used by def_line_store, def_level and diagonal_emboss_filter.
package def_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 12;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd640;
   localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 12'd2;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);

   localparam logic [7:0] MID_LEVEL = 8'd128;
   localparam logic [7:0] MAX_LEVEL = 8'd255;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

endpackage

// ===== rtl/def_line_store.sv =====
// def_line_store: previous-row pixel memory with registered read.
// Read returns the old entry while the same address is overwritten. Depends on def_pkg.
module def_line_store
   import def_pkg::*;
(
   input  logic             clock,
   input  logic             wr_en,
   input  logic [COL_W-1:0] addr,
   input  pixel_type        wr_data,
   output pixel_type        rd_data
);

   pixel_type store_ff [MAX_WIDTH];
   pixel_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rd_data_ff     <= store_ff[addr];
         store_ff[addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/def_level.sv =====
// def_level: picks the largest-magnitude channel difference against the
// diagonal neighbor, offsets by 128 and clamps. Depends on def_pkg.
module def_level
   import def_pkg::*;
(
   input  pixel_type  cur,
   input  pixel_type  diag,
   input  logic       border,
   output logic [7:0] level
);

   logic signed [9:0] db, dg, dr;
   logic        [8:0] ab, ag, ar;
   logic signed [9:0] pick;
   logic signed [9:0] sum;

   always_comb begin
      db = $signed({2'b00, cur.blue})  - $signed({2'b00, diag.blue});
      dg = $signed({2'b00, cur.green}) - $signed({2'b00, diag.green});
      dr = $signed({2'b00, cur.red})   - $signed({2'b00, diag.red});
      ab = db[9] ? 9'(-db) : db[8:0];
      ag = dg[9] ? 9'(-dg) : dg[8:0];
      ar = dr[9] ? 9'(-dr) : dr[8:0];

      if (ar < ab) begin
         pick = (ab < ag) ? dg : db;
      end else begin
         pick = (ar < ag) ? dg : dr;
      end
      sum = pick + 10'sd128;

      if (border) begin
         level = MID_LEVEL;
      end else if (sum < 10'sd0) begin
         level = 8'd0;
      end else if (sum > 10'sd255) begin
         level = MAX_LEVEL;
      end else begin
         level = sum[7:0];
      end
   end

endmodule

// ===== rtl/diagonal_emboss_filter.sv =====
// diagonal_emboss_filter: top level of the diagonal emboss filter.
// Instantiates def_line_store and def_level; depends on def_pkg.
//
// Usage:
//   Pixels arrive in raster order on the req_ channel (blue, green, red,
//   frame_start); each transaction yields exactly one rsp_ transaction
//   carrying the grey emboss level. req_frame_start marks the first pixel of
//   an image and restarts the row and column position.
//   csr_wr_data sets the row width (effective range 2..2048) and is written
//   whenever csr_wr_en is high; change it only while the block is idle.
//   Responses are registered in the output or skid register; throughput is one
//   pixel per cycle while req_stall is low, set by the single read/write port
//   of the line store, which is read and written once per transaction.
//   Pixels of the first row or first column give 128.
//   A two-entry output buffer (output register plus skid register) parts the
//   channels: req_stall comes from a register and rises only once both
//   entries are full, so one more pixel is taken while a response is stalled.
//   Reset (synchronous) empties the output buffer, sets the width to 640 and
//   starts at row 0, column 0. The line store needs no clearing pass.
module diagonal_emboss_filter
   import def_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_blue,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_red,
   input  logic               req_frame_start,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_emboss_value,
   input  logic               csr_wr_en,
   input  logic [WIDTH_W-1:0] csr_wr_data
);

   logic [WIDTH_W-1:0] width_ff;
   logic [COL_W-1:0]   col_ff, col_in;
   logic               first_row_ff, first_row_in;
   logic               rsp_valid_ff, skid_valid_ff;
   logic [7:0]         rsp_value_ff, skid_value_ff;

   logic               accept, take;
   logic [COL_W-1:0]   col_cur;
   logic               first_row_cur;
   logic [WIDTH_W-1:0] width_eff;
   logic [WIDTH_W-1:0] col_next;
   logic               wrap;
   pixel_type          cur_pix, diag_pix;
   logic [7:0]         level;

   assign accept = req_valid & ~req_stall;
   assign take   = rsp_valid_ff & ~rsp_stall;

   assign cur_pix = '{red: req_red, green: req_green, blue: req_blue};

   always_comb begin
      col_cur       = req_frame_start ? '0 : col_ff;
      first_row_cur = req_frame_start | first_row_ff;
      if (width_ff < WIDTH_MIN) begin
         width_eff = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = width_ff;
      end
      col_next     = {1'b0, col_cur} + WIDTH_W'(1);
      wrap         = (col_next >= width_eff);
      col_in       = wrap ? '0 : col_next[COL_W-1:0];
      first_row_in = wrap ? 1'b0 : first_row_cur;
   end

   def_line_store u_line_store (
      .clock   (clock),
      .wr_en   (accept),
      .addr    (col_cur),
      .wr_data (cur_pix),
      .rd_data (diag_pix)
   );

   def_level u_level (
      .cur    (cur_pix),
      .diag   (diag_pix),
      .border (first_row_cur | (col_cur == '0)),
      .level  (level)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
      end else if (csr_wr_en) begin
         width_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         first_row_ff <= 1'b1;
      end else if (accept) begin
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
      end
   end

   // output register plus skid register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (rsp_valid_ff & ~take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            rsp_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_value_ff <= skid_value_ff;
         end
      end else if (accept) begin
         if (rsp_valid_ff & ~take) begin
            skid_value_ff <= level;
         end else begin
            rsp_value_ff <= level;
         end
      end
   end

   assign req_stall        = skid_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_emboss_value = rsp_value_ff;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without an output entry");

   a_stall_fills_skid: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("transaction accepted under stall was not buffered");

   a_frame_start_pos: assert property (@(posedge clock) disable iff (reset)
      (accept && req_frame_start) |=> (col_ff == COL_W'(1)) && first_row_ff)
      else $error("frame start did not restart the position");

endmodule
